/* rtl/core/rfss_pkg.sv */
// Shared types, codes and helpers for the correction-stream frame scanner.
// No dependencies; imported by rfss_parser and rtcm3_frame_scanner_stats.

package rfss_pkg;

   // Request operation codes
   typedef enum logic [1:0] {
      OP_BYTE  = 2'd0,
      OP_TICK  = 2'd1,
      OP_CLEAR = 2'd2
   } rfss_op_type;

   // Parser phases
   typedef enum logic [1:0] {
      PH_HUNT = 2'd0,
      PH_LEN1 = 2'd1,
      PH_LEN2 = 2'd2,
      PH_BODY = 2'd3
   } rfss_phase_type;

   localparam logic [7:0]  PREAMBLE        = 8'hD3;
   localparam logic [1:0]  LEN_HIGH_MASK   = 2'h3;
   localparam logic [10:0] FRAME_OVERHEAD  = 11'd6;
   localparam int unsigned CRC_BYTES       = 3;
   localparam logic [15:0] WINDOW_MS_RESET = 16'd1000;

   // Frame state after the current request, parser to top level
   typedef struct packed {
      logic        done;
      logic [11:0] msg_type;
      logic        type_valid;
      logic [10:0] frame_length;
   } rfss_frame_type;

   // One response
   typedef struct packed {
      logic        frame_done;
      logic [11:0] msg_type;
      logic        type_valid;
      logic [10:0] frame_length;
      logic [31:0] frame_count;
      logic [31:0] bytes_received;
      logic [31:0] rate_bytes;
      logic [31:0] age_ms;
      logic        age_valid;
   } rfss_rsp_type;

   // Saturating increment of a 32-bit counter
   function automatic logic [31:0] sat_inc32(input logic [31:0] value);
      sat_inc32 = (value == 32'hFFFF_FFFF) ? value : value + 32'd1;
   endfunction

endpackage

/* rtl/core/rfss_parser.sv */
// Byte-serial frame parser: preamble hunt, length, body and CRC count-out.
// Depends on rfss_pkg; instantiated by rtcm3_frame_scanner_stats.

module rfss_parser
   import rfss_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 1023
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_en,
   input  logic           clear_en,
   input  logic [7:0]     data_byte,
   output rfss_frame_type frame
);

   localparam int unsigned BodyWidth = $clog2(MAX_PAYLOAD + CRC_BYTES + 1);

   rfss_phase_type        phase_ff, phase_in;
   logic [1:0]            len_high_ff, len_high_in;
   logic [BodyWidth-1:0]  remain_ff, remain_in;
   logic [1:0]            pos_ff, pos_in;        // body position, saturates at 2
   logic [10:0]           total_ff, total_in;
   logic                  long_ff, long_in;      // payload of two bytes or more
   logic [7:0]            type_high_ff, type_high_in;
   logic [11:0]           last_type_ff, last_type_in;
   logic                  type_valid_ff, type_valid_in;
   logic [10:0]           last_len_ff, last_len_in;
   logic                  done;

   logic [9:0]            payload;
   logic                  too_long;
   logic                  last_body;

   assign payload   = {len_high_ff, data_byte};
   assign too_long  = payload > 10'(MAX_PAYLOAD);
   assign last_body = remain_ff == BodyWidth'(1);

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (clear_en) begin
         phase_in = PH_HUNT;
      end else if (byte_en) begin
         unique case (phase_ff)
            PH_HUNT: if (data_byte == PREAMBLE) phase_in = PH_LEN1;
            PH_LEN1: phase_in = PH_LEN2;
            PH_LEN2: phase_in = too_long ? PH_HUNT : PH_BODY;
            PH_BODY: if (last_body) phase_in = PH_HUNT;
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   // Length, body counting and type capture
   always_comb begin
      len_high_in   = len_high_ff;
      remain_in     = remain_ff;
      pos_in        = pos_ff;
      total_in      = total_ff;
      long_in       = long_ff;
      type_high_in  = type_high_ff;
      last_type_in  = last_type_ff;
      type_valid_in = type_valid_ff;
      last_len_in   = last_len_ff;
      done          = 1'b0;
      if (clear_en) begin
         len_high_in   = '0;
         remain_in     = '0;
         pos_in        = '0;
         total_in      = '0;
         long_in       = 1'b0;
         type_high_in  = '0;
         last_type_in  = '0;
         type_valid_in = 1'b0;
         last_len_in   = '0;
      end else if (byte_en) begin
         unique case (phase_ff)
            PH_HUNT: ;
            PH_LEN1: len_high_in = data_byte[1:0] & LEN_HIGH_MASK;
            PH_LEN2: begin
               // oversized length drops the frame, counters untouched
               if (!too_long) begin
                  total_in  = 11'(payload) + FRAME_OVERHEAD;
                  remain_in = BodyWidth'(payload) + BodyWidth'(CRC_BYTES);
                  pos_in    = 2'd0;
                  long_in   = payload >= 10'd2;
               end
            end
            PH_BODY: begin
               if (pos_ff == 2'd0) begin
                  type_high_in = data_byte;
               end else if (pos_ff == 2'd1 && long_ff) begin
                  last_type_in  = {type_high_ff, data_byte[7:4]};
                  type_valid_in = 1'b1;
               end
               pos_in    = (pos_ff == 2'd2) ? pos_ff : pos_ff + 2'd1;
               remain_in = remain_ff - BodyWidth'(1);
               if (last_body) begin
                  last_len_in = total_ff;
                  done        = 1'b1;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_HUNT;
         len_high_ff   <= '0;
         remain_ff     <= '0;
         pos_ff        <= '0;
         total_ff      <= '0;
         long_ff       <= 1'b0;
         type_high_ff  <= '0;
         last_type_ff  <= '0;
         type_valid_ff <= 1'b0;
         last_len_ff   <= '0;
      end else begin
         phase_ff      <= phase_in;
         len_high_ff   <= len_high_in;
         remain_ff     <= remain_in;
         pos_ff        <= pos_in;
         total_ff      <= total_in;
         long_ff       <= long_in;
         type_high_ff  <= type_high_in;
         last_type_ff  <= last_type_in;
         type_valid_ff <= type_valid_in;
         last_len_ff   <= last_len_in;
      end
   end

   // State as it stands after this request
   assign frame.done         = done;
   assign frame.msg_type     = last_type_in;
   assign frame.type_valid   = type_valid_in;
   assign frame.frame_length = last_len_in;

endmodule

/* rtl/core/rtcm3_frame_scanner_stats.sv */
// Top level of the correction-stream frame scanner with link statistics.
// Depends on rfss_pkg and rfss_parser.

// Each request (byte, millisecond tick or clear) is handled in the cycle it
// is accepted and its response is registered, so a request can be taken in
// every cycle while req_stall is low. The response side has an output
// register plus one skid entry; req_stall rises only when both hold
// responses that downstream has not yet taken. Every request gives exactly
// one response carrying the statistics after it. window_ms is written through
// csr_wr_en/csr_wr_data and should change only while the block is idle; zero
// acts as one.

module rtcm3_frame_scanner_stats
   import rfss_pkg::*;
#(
   parameter int unsigned MAX_PAYLOAD = 1023
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_operation,
   input  logic [7:0]  req_data_byte,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_frame_done,
   output logic [11:0] rsp_msg_type,
   output logic        rsp_type_valid,
   output logic [10:0] rsp_frame_length,
   output logic [31:0] rsp_frame_count,
   output logic [31:0] rsp_bytes_received,
   output logic [31:0] rsp_rate_bytes,
   output logic [31:0] rsp_age_ms,
   output logic        rsp_age_valid,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data
);

   logic           accept;
   logic           take;
   logic           byte_en;
   logic           tick_en;
   logic           clear_en;
   rfss_frame_type frame;
   rfss_rsp_type   rsp_new;

   logic [15:0]    window_ms_ff;
   logic [15:0]    limit;
   logic [15:0]    ticks_next;

   logic [31:0]    frames_ff, frames_in;
   logic [31:0]    bytes_ff, bytes_in;
   logic [31:0]    win_bytes_ff, win_bytes_in;
   logic [15:0]    ticks_ff, ticks_in;
   logic [31:0]    rate_ff, rate_in;
   logic [31:0]    since_ff, since_in;
   logic           seen_ff, seen_in;
   logic [31:0]    age_ff, age_in;
   logic           age_valid_ff, age_valid_in;

   logic           out_valid_ff, out_valid_in;
   rfss_rsp_type   out_data_ff, out_data_in;
   logic           skid_valid_ff, skid_valid_in;
   rfss_rsp_type   skid_data_ff, skid_data_in;

   // Handshake
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && !skid_valid_ff;
   assign take      = out_valid_ff && !rsp_stall;
   assign byte_en   = accept && (req_operation == OP_BYTE);
   assign tick_en   = accept && (req_operation == OP_TICK);
   assign clear_en  = accept && (req_operation == OP_CLEAR);

   // Window length register
   always_ff @(posedge clock) begin
      if (reset) begin
         window_ms_ff <= WINDOW_MS_RESET;
      end else if (csr_wr_en) begin
         window_ms_ff <= csr_wr_data;
      end
   end

   rfss_parser #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .byte_en   (byte_en),
      .clear_en  (clear_en),
      .data_byte (req_data_byte),
      .frame     (frame)
   );

   assign limit      = (window_ms_ff == 16'd0) ? 16'd1 : window_ms_ff;
   assign ticks_next = ticks_ff + 16'd1;

   // Counters, window and age
   always_comb begin
      frames_in    = frames_ff;
      bytes_in     = bytes_ff;
      win_bytes_in = win_bytes_ff;
      ticks_in     = ticks_ff;
      rate_in      = rate_ff;
      since_in     = since_ff;
      seen_in      = seen_ff;
      age_in       = age_ff;
      age_valid_in = age_valid_ff;
      if (clear_en) begin
         // tick counter keeps running across a clear
         frames_in    = '0;
         bytes_in     = '0;
         win_bytes_in = '0;
         rate_in      = '0;
         since_in     = '0;
         seen_in      = 1'b0;
         age_in       = '0;
         age_valid_in = 1'b0;
      end else if (byte_en) begin
         bytes_in     = sat_inc32(bytes_ff);
         win_bytes_in = sat_inc32(win_bytes_ff);
         since_in     = '0;
         seen_in      = 1'b1;
         if (frame.done) frames_in = sat_inc32(frames_ff);
      end else if (tick_en) begin
         since_in = sat_inc32(since_ff);
         ticks_in = ticks_next;
         if (ticks_next >= limit) begin
            rate_in      = win_bytes_ff;
            win_bytes_in = '0;
            ticks_in     = '0;
            if (seen_ff) begin
               age_in       = since_in;
               age_valid_in = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff    <= '0;
         bytes_ff     <= '0;
         win_bytes_ff <= '0;
         ticks_ff     <= '0;
         rate_ff      <= '0;
         since_ff     <= '0;
         seen_ff      <= 1'b0;
         age_ff       <= '0;
         age_valid_ff <= 1'b0;
      end else begin
         frames_ff    <= frames_in;
         bytes_ff     <= bytes_in;
         win_bytes_ff <= win_bytes_in;
         ticks_ff     <= ticks_in;
         rate_ff      <= rate_in;
         since_ff     <= since_in;
         seen_ff      <= seen_in;
         age_ff       <= age_in;
         age_valid_ff <= age_valid_in;
      end
   end

   // Response for the request accepted this cycle
   always_comb begin
      rsp_new.frame_done     = byte_en && frame.done;
      rsp_new.msg_type       = frame.msg_type;
      rsp_new.type_valid     = frame.type_valid;
      rsp_new.frame_length   = frame.frame_length;
      rsp_new.frame_count    = frames_in;
      rsp_new.bytes_received = bytes_in;
      rsp_new.rate_bytes     = rate_in;
      rsp_new.age_ms         = age_in;
      rsp_new.age_valid      = age_valid_in;
   end

   // Output register with one skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (take) begin
         if (skid_valid_ff) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else if (accept) begin
            out_data_in = rsp_new;
         end else begin
            out_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff) begin
            out_valid_in = 1'b1;
            out_data_in  = rsp_new;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = rsp_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_frame_done     = out_data_ff.frame_done;
   assign rsp_msg_type       = out_data_ff.msg_type;
   assign rsp_type_valid     = out_data_ff.type_valid;
   assign rsp_frame_length   = out_data_ff.frame_length;
   assign rsp_frame_count    = out_data_ff.frame_count;
   assign rsp_bytes_received = out_data_ff.bytes_received;
   assign rsp_rate_bytes     = out_data_ff.rate_bytes;
   assign rsp_age_ms         = out_data_ff.age_ms;
   assign rsp_age_valid      = out_data_ff.age_valid;

   // Checks
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held without an output entry");

   a_done_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (rsp_frame_count != 32'd0))
      else $error("frame completed but frame count is zero");

   a_done_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_done) |-> (rsp_frame_length >= FRAME_OVERHEAD))
      else $error("completed frame shorter than its header and CRC");

   a_age_needs_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_age_valid) |-> (rsp_bytes_received != 32'd0))
      else $error("age valid with no bytes received");

endmodule

/* bench/rtcm3_frame_scanner_stats_tb.sv */
// Self-checking bench for rtcm3_frame_scanner_stats: frames, ticks, clears and window settings.
// Depends on rfss_pkg for the operation codes, the response layout and the frame constants.

module rtcm3_frame_scanner_stats_tb
   import rfss_pkg::*;
();

   localparam int unsigned PAYLOAD_LIMIT = 1023;
   localparam int unsigned LONG_HOLD     = 300;
   localparam int unsigned CYCLE_LIMIT   = 400000;
   localparam int unsigned PHASE_ITEMS   = 96;
   localparam logic [1:0]  OP_NONE       = 2'd3;

   // Predicts the link statistics after each request and checks the responses against them
   class frame_stats_checker;
      logic [15:0]    window_len;
      logic [15:0]    win_ticks;
      rfss_phase_type parse_state;
      logic [1:0]     len_high;
      logic [9:0]     payload_len;
      logic [10:0]    body_left, body_pos, frame_total, last_len;
      logic [7:0]     type_high;
      logic [11:0]    last_type;
      logic           type_seen, data_seen, age_seen;
      logic [31:0]    frames, bytes_seen, win_bytes, rate, since_byte, age;
      int unsigned    failures;
      rfss_rsp_type   due_stats[$];

      function new();
         window_len = WINDOW_MS_RESET;
         win_ticks  = '0;
         failures   = 0;
         clear_all();
      endfunction

      // Clear leaves the tick counter and the window length alone
      function void clear_all();
         parse_state = PH_HUNT;
         len_high    = '0;
         payload_len = '0;
         body_left   = '0;
         body_pos    = '0;
         frame_total = '0;
         type_high   = '0;
         last_type   = '0;
         type_seen   = 1'b0;
         last_len    = '0;
         frames      = '0;
         bytes_seen  = '0;
         win_bytes   = '0;
         rate        = '0;
         since_byte  = '0;
         data_seen   = 1'b0;
         age         = '0;
         age_seen    = 1'b0;
      endfunction

      function logic [31:0] bump(input logic [31:0] v);
         return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
      endfunction

      function void set_window(input logic [15:0] v);
         window_len = v;
      endfunction

      function int pending();
         return due_stats.size();
      endfunction

      // Accepted request: advance the parser and counters, queue the statistics
      function void take_request(input logic [1:0] op, input logic [7:0] data);
         rfss_rsp_type want;
         logic         done;
         logic [15:0]  limit;
         done = 1'b0;
         case (op)
            OP_BYTE: begin
               bytes_seen = bump(bytes_seen);
               win_bytes  = bump(win_bytes);
               since_byte = '0;
               data_seen  = 1'b1;
               case (parse_state)
                  PH_HUNT: begin
                     if (data == PREAMBLE) parse_state = PH_LEN1;
                  end
                  PH_LEN1: begin
                     len_high    = data[1:0];
                     parse_state = PH_LEN2;
                  end
                  PH_LEN2: begin
                     payload_len = {len_high, data};
                     if (payload_len > PAYLOAD_LIMIT) begin
                        parse_state = PH_HUNT;
                     end else begin
                        frame_total = 11'(payload_len) + FRAME_OVERHEAD;
                        body_left   = 11'(payload_len) + 11'(CRC_BYTES);
                        body_pos    = '0;
                        parse_state = PH_BODY;
                     end
                  end
                  default: begin
                     // first two payload bytes carry the message type
                     if (body_pos == 11'd0) begin
                        type_high = data;
                     end else if (body_pos == 11'd1 && payload_len >= 10'd2) begin
                        last_type = {type_high, data[7:4]};
                        type_seen = 1'b1;
                     end
                     body_pos  = body_pos + 11'd1;
                     body_left = body_left - 11'd1;
                     if (body_left == 11'd0) begin
                        last_len    = frame_total;
                        frames      = bump(frames);
                        parse_state = PH_HUNT;
                        done        = 1'b1;
                     end
                  end
               endcase
            end
            OP_TICK: begin
               limit      = (window_len == 16'd0) ? 16'd1 : window_len;
               since_byte = bump(since_byte);
               win_ticks  = win_ticks + 16'd1;
               if (win_ticks >= limit) begin
                  rate      = win_bytes;
                  win_bytes = '0;
                  win_ticks = '0;
                  if (data_seen) begin
                     age      = since_byte;
                     age_seen = 1'b1;
                  end
               end
            end
            OP_CLEAR: clear_all();
            default: ;
         endcase
         want.frame_done     = done;
         want.msg_type       = last_type;
         want.type_valid     = type_seen;
         want.frame_length   = last_len;
         want.frame_count    = frames;
         want.bytes_received = bytes_seen;
         want.rate_bytes     = rate;
         want.age_ms         = age;
         want.age_valid      = age_seen;
         due_stats.push_back(want);
      endfunction

      function void compare(input string name, input logic [31:0] want_v,
                            input logic [31:0] got_v);
         if (want_v !== got_v) begin
            failures++;
            $display("%0t: %s expected %0h actual %0h", $time, name, want_v, got_v);
         end
      endfunction

      // Accepted response: compare with the oldest prediction
      function void check_stats(input rfss_rsp_type got);
         rfss_rsp_type want;
         if (due_stats.size() == 0) begin
            failures++;
            $display("%0t: response expected none actual %p", $time, got);
            return;
         end
         want = due_stats.pop_front();
         compare("frame_done", want.frame_done, got.frame_done);
         compare("msg_type", want.msg_type, got.msg_type);
         compare("type_valid", want.type_valid, got.type_valid);
         compare("frame_length", want.frame_length, got.frame_length);
         compare("frame_count", want.frame_count, got.frame_count);
         compare("bytes_received", want.bytes_received, got.bytes_received);
         compare("rate_bytes", want.rate_bytes, got.rate_bytes);
         compare("age_ms", want.age_ms, got.age_ms);
         compare("age_valid", want.age_valid, got.age_valid);
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid, req_stall;
   logic [1:0]  req_operation;
   logic [7:0]  req_data_byte;
   logic        rsp_valid, rsp_stall;
   logic        rsp_frame_done, rsp_type_valid, rsp_age_valid;
   logic [11:0] rsp_msg_type;
   logic [10:0] rsp_frame_length;
   logic [31:0] rsp_frame_count, rsp_bytes_received, rsp_rate_bytes, rsp_age_ms;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;

   frame_stats_checker sb = new();
   int unsigned item_count  = 0;
   int unsigned run_left    = 0;
   int unsigned cycle_count = 0;
   logic        quiet       = 1'b0;
   logic        hold_due    = 1'b0;
   logic [15:0] window_plan [6] = '{16'd1, 16'd0, 16'd5, 16'hFFFF, 16'd3, 16'd2};

   rtcm3_frame_scanner_stats #(
      .MAX_PAYLOAD(PAYLOAD_LIMIT)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_operation      (req_operation),
      .req_data_byte      (req_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_msg_type       (rsp_msg_type),
      .rsp_type_valid     (rsp_type_valid),
      .rsp_frame_length   (rsp_frame_length),
      .rsp_frame_count    (rsp_frame_count),
      .rsp_bytes_received (rsp_bytes_received),
      .rsp_rate_bytes     (rsp_rate_bytes),
      .rsp_age_ms         (rsp_age_ms),
      .rsp_age_valid      (rsp_age_valid),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Handshake monitor: note accepted requests, check accepted responses
   always @(posedge clock) begin
      rfss_rsp_type seen;
      if (!reset) begin
         if (req_valid && !req_stall) sb.take_request(req_operation, req_data_byte);
         if (rsp_valid && !rsp_stall) begin
            seen.frame_done     = rsp_frame_done;
            seen.msg_type       = rsp_msg_type;
            seen.type_valid     = rsp_type_valid;
            seen.frame_length   = rsp_frame_length;
            seen.frame_count    = rsp_frame_count;
            seen.bytes_received = rsp_bytes_received;
            seen.rate_bytes     = rsp_rate_bytes;
            seen.age_ms         = rsp_age_ms;
            seen.age_valid      = rsp_age_valid;
            sb.check_stats(seen);
         end
      end
   end

   // Receiver: stall bursts between free runs, one long hold-off, none at the end
   initial begin
      logic stall_next;
      stall_next = 1'b0;
      rsp_stall <= 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (quiet) begin
            rsp_stall <= 1'b0;
         end else if (hold_due) begin
            hold_due = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else if (stall_next) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(0, 16)) @(posedge clock);
            stall_next = 1'b0;
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(0, 39)) @(posedge clock);
            stall_next = 1'b1;
         end
      end
   end

   // One request, held until accepted; idle bursts fall between runs of requests
   task automatic send_request(input logic [1:0] op, input logic [7:0] data);
      req_valid     <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      item_count++;
      if (!quiet) begin
         if (run_left > 0) begin
            run_left--;
         end else begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
            run_left = $urandom_range(0, 40);
         end
      end
   endtask

   // Preamble, length header with random reserved bits, then keep body bytes
   task automatic send_frame(input int unsigned plen, input int unsigned keep,
                             input logic [7:0] lead0, input logic [7:0] lead1);
      logic [9:0]  len10;
      logic [7:0]  b;
      int unsigned i;
      len10 = plen[9:0];
      send_request(OP_BYTE, PREAMBLE);
      send_request(OP_BYTE, {6'($urandom), len10[9:8]});
      send_request(OP_BYTE, len10[7:0]);
      for (i = 0; i < keep; i++) begin
         if (i == 0) b = lead0;
         else if (i == 1) b = lead1;
         else b = 8'($urandom);
         send_request(OP_BYTE, b);
      end
   endtask

   // Mostly whole frames; the rest ticks, line noise, cut-off frames, stray codes and clears
   task automatic random_action();
      int unsigned pick, plen, n;
      logic [7:0]  b;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         plen = ($urandom_range(0, 19) == 0) ? $urandom_range(13, 300) : $urandom_range(0, 12);
         send_frame(plen, plen + 3, 8'($urandom), 8'($urandom));
      end else if (pick < 65) begin
         plen = $urandom_range(0, 1023);
         n    = $urandom_range(0, (plen + 2 < 8) ? plen + 2 : 8);
         send_frame(plen, n, 8'($urandom), 8'($urandom));
         send_request(OP_CLEAR, 8'($urandom));
      end else if (pick < 80) begin
         repeat ($urandom_range(1, 5)) send_request(OP_TICK, 8'($urandom));
      end else if (pick < 92) begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            b = 8'($urandom);
            if (b == PREAMBLE) b = ~b;
            send_request(OP_BYTE, b);
         end
      end else if (pick < 96) begin
         send_request(OP_NONE, 8'($urandom));
      end else begin
         send_request(OP_CLEAR, 8'($urandom));
      end
   endtask

   // Let every outstanding response come back before touching the register
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_window(input logic [15:0] v);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      sb.set_window(v);
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int          p;
      int unsigned phase_start;
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_operation <= OP_BYTE;
      req_data_byte <= 8'h00;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= 16'h0000;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: window end before data, stray code, short frames, age latch, clear
      write_window(16'd2);
      send_request(OP_TICK, 8'h00);
      send_request(OP_TICK, 8'hFF);
      send_request(OP_NONE, 8'hA5);
      send_request(OP_BYTE, 8'h55);
      send_frame(0, 3, 8'h00, 8'hFF);
      send_frame(1, 4, 8'hAB, 8'h00);
      send_frame(2, 5, 8'hFF, 8'hF0);
      send_frame(2, 5, 8'h00, 8'h0F);
      send_request(OP_TICK, 8'h3C);
      send_request(OP_TICK, 8'hC3);
      send_request(OP_CLEAR, 8'h00);

      // Longest legal length, cut off part way and cleared
      send_frame(PAYLOAD_LIMIT, 6, 8'h3E, 8'hD0);
      send_request(OP_CLEAR, 8'h00);

      // Random phases, one window setting each
      for (p = 0; p < 6; p++) begin
         wait_drained();
         write_window(window_plan[p]);
         if (p == 1) hold_due = 1'b1;
         if (p == 5) quiet = 1'b1;
         phase_start = item_count;
         while (item_count - phase_start < PHASE_ITEMS) random_action();
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (sb.failures == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
